// ===== hdl/darcy_forchheimer_law_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Darcy-Forchheimer law unit assertion macros
// Concurrent check helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DARCY_FORCHHEIMER_LAW_UNIT_ASSERT_SVH
`define DARCY_FORCHHEIMER_LAW_UNIT_ASSERT_SVH

// same-cycle implication
`define DFL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("darcy_forchheimer_law_unit check failed");

// next-cycle implication
`define DFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("darcy_forchheimer_law_unit check failed");

`endif

// ===== hdl/dfl_pkg.sv =====
// ----------------------------------------------------------------------------
// dfl_pkg
// Widths, status codes and pipeline types for the Darcy-Forchheimer law unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfl_pkg;

    localparam int FRAC_BITS = 16;

    localparam int A_W     = 32;                 // coefficient width
    localparam int V_W     = 32;                 // velocity width
    localparam int P_W     = 48;                 // pressure jump width
    localparam int PROD_W  = 64;                 // 32x32 product
    localparam int QUAD_W  = PROD_W - FRAC_BITS; // b*|v| rescaled
    localparam int SUM_W   = QUAD_W + 1;         // a + b*|v|
    localparam int SUMHI_W = SUM_W - 32;
    localparam int JLO_W   = V_W + 32;
    localparam int JHI_W   = V_W + SUMHI_W;
    localparam int JFULL_W = V_W + SUM_W;
    localparam int JMAG_W  = JFULL_W - FRAC_BITS;
    localparam int MHI_W   = A_W + P_W - 32;
    localparam int BP_W    = A_W + P_W;          // b*|P|
    localparam int RAD_W   = BP_W + 3;           // a^2 + 4*b*|P|
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int RADP_W  = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int NUM_W   = P_W + FRAC_BITS + 1; // 2*|P| rescaled
    localparam int DREM_W  = DEN_W + 1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_COEF_ZERO  = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;

    // per-item control carried along the whole pipe
    typedef struct packed {
        logic             req;
        logic             coef_zero;
        logic             res_neg;
        logic             pzero;
        logic             jsat;
        logic [A_W-1:0]   a;
        logic [P_W-1:0]   pmag;
        logic [P_W-1:0]   jump;
    } ctrl_t;

    typedef struct packed {
        logic [P_W-1:0] jump;
        logic [V_W-1:0] vel;
        logic [1:0]     status;
    } res_t;

endpackage

// ===== hdl/darcy_forchheimer_law_unit.sv =====
// ----------------------------------------------------------------------------
// darcy_forchheimer_law_unit
// Fixed-point Darcy-Forchheimer porous law: velocity to jump and jump back.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer accepted per clock while in_ready is high,
// one result per transfer, in order. The path runs through stages A to D,
// the bit-per-stage square root (ROOT_W stages), stage E, the bit-per-stage
// restoring divider (NUM_W stages) and the output register.
// Velocity requests compute -v*(a + b|v|) in four multiply/add
// stages and ride along the root and divider stages unchanged. A two-entry
// output (output register plus skid register) parts the sides: in_ready is
// a register bit, low only while the skid register holds a result, and the
// whole pipe holds in that cycle. No clearing pass; ready right after reset.
`timescale 1ns / 1ps
`include "darcy_forchheimer_law_unit_assert.svh"

module darcy_forchheimer_law_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [dfl_pkg::A_W-1:0]     lin_coeff,
    input  logic [dfl_pkg::A_W-1:0]     quad_coeff,
    input  logic signed [dfl_pkg::V_W-1:0] velocity_in,
    input  logic signed [dfl_pkg::P_W-1:0] jump_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [dfl_pkg::P_W-1:0] jump_out,
    output logic signed [dfl_pkg::V_W-1:0] velocity_out,
    output logic [1:0]                  status
);

    localparam int A_W     = dfl_pkg::A_W;
    localparam int V_W     = dfl_pkg::V_W;
    localparam int P_W     = dfl_pkg::P_W;
    localparam int F       = dfl_pkg::FRAC_BITS;
    localparam int PROD_W  = dfl_pkg::PROD_W;
    localparam int SUM_W   = dfl_pkg::SUM_W;
    localparam int JLO_W   = dfl_pkg::JLO_W;
    localparam int JHI_W   = dfl_pkg::JHI_W;
    localparam int JFULL_W = dfl_pkg::JFULL_W;
    localparam int JMAG_W  = dfl_pkg::JMAG_W;
    localparam int MHI_W   = dfl_pkg::MHI_W;
    localparam int BP_W    = dfl_pkg::BP_W;
    localparam int RAD_W   = dfl_pkg::RAD_W;
    localparam int ROOT_W  = dfl_pkg::ROOT_W;
    localparam int RADP_W  = dfl_pkg::RADP_W;
    localparam int REM_W   = dfl_pkg::REM_W;
    localparam int DEN_W   = dfl_pkg::DEN_W;
    localparam int NUM_W   = dfl_pkg::NUM_W;
    localparam int DREM_W  = dfl_pkg::DREM_W;

    // global advance: pipe moves whenever the skid register is free
    logic adv;
    logic skid_valid_reg;
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage A: magnitudes and first products
    // ------------------------------------------------------------------
    logic               vneg_c, pneg_c;
    logic [V_W-1:0]     vmag_c;
    logic [P_W-1:0]     pmag_c;
    logic [31:0]        mop_c;
    dfl_pkg::ctrl_t     ctrl_in_c;

    always_comb
    begin
        vneg_c = velocity_in[V_W-1];
        pneg_c = jump_in[P_W-1];
        // two's complement of the minimum maps onto its own magnitude
        vmag_c = vneg_c ? (~$unsigned(velocity_in) + V_W'(1)) : $unsigned(velocity_in);
        pmag_c = pneg_c ? (~$unsigned(jump_in) + P_W'(1)) : $unsigned(jump_in);
        mop_c  = req_type ? pmag_c[31:0] : vmag_c;
        ctrl_in_c           = '0;
        ctrl_in_c.req       = req_type;
        ctrl_in_c.coef_zero = (lin_coeff == '0) && (quad_coeff == '0);
        ctrl_in_c.res_neg   = req_type ? !pneg_c : !vneg_c;
        ctrl_in_c.pzero     = (pmag_c == '0);
        ctrl_in_c.a         = lin_coeff;
        ctrl_in_c.pmag      = pmag_c;
    end

    logic                a_valid_reg;
    dfl_pkg::ctrl_t      a_ctrl_reg;
    logic [V_W-1:0]      a_vmag_reg;
    logic [PROD_W-1:0]   a_mlo_reg;
    logic [MHI_W-1:0]    a_mhi_reg;
    logic [PROD_W-1:0]   a_aa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ctrl_reg <= ctrl_in_c;
            a_vmag_reg <= vmag_c;
            a_mlo_reg  <= PROD_W'(quad_coeff) * PROD_W'(mop_c);
            a_mhi_reg  <= MHI_W'(quad_coeff) * MHI_W'(pmag_c[P_W-1:32]);
            a_aa_reg   <= PROD_W'(lin_coeff) * PROD_W'(lin_coeff);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: a + b|v| and the radicand a^2 + 4b|P|
    // ------------------------------------------------------------------
    logic [BP_W-1:0]  bp_c;
    logic [SUM_W-1:0] sum_c;
    logic [RAD_W-1:0] rad_c;

    always_comb
    begin
        sum_c = SUM_W'(a_ctrl_reg.a) + SUM_W'(a_mlo_reg >> F);
        bp_c  = BP_W'(a_mlo_reg) + (BP_W'(a_mhi_reg) << 32);
        rad_c = RAD_W'(a_aa_reg) + (RAD_W'(bp_c) << 2);
    end

    logic              b_valid_reg;
    dfl_pkg::ctrl_t    b_ctrl_reg;
    logic [V_W-1:0]    b_vmag_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [RAD_W-1:0]  b_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ctrl_reg <= a_ctrl_reg;
            b_vmag_reg <= a_vmag_reg;
            b_sum_reg  <= sum_c;
            b_rad_reg  <= rad_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: |v| * (a + b|v|) as two partial products
    // ------------------------------------------------------------------
    logic              c_valid_reg;
    dfl_pkg::ctrl_t    c_ctrl_reg;
    logic [JLO_W-1:0]  c_jlo_reg;
    logic [JHI_W-1:0]  c_jhi_reg;
    logic [RAD_W-1:0]  c_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_ctrl_reg <= b_ctrl_reg;
            c_jlo_reg  <= JLO_W'(b_vmag_reg) * JLO_W'(b_sum_reg[31:0]);
            c_jhi_reg  <= JHI_W'(b_vmag_reg) * JHI_W'(b_sum_reg[SUM_W-1:32]);
            c_rad_reg  <= b_rad_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: jump magnitude, saturation and sign
    // ------------------------------------------------------------------
    logic [JFULL_W-1:0] jfull_c;
    logic [JMAG_W-1:0]  jmag_c;
    logic [P_W-1:0]     jlim_c, jm_c;
    logic               jsat_c;
    dfl_pkg::ctrl_t     d_ctrl_c;

    always_comb
    begin
        jfull_c = JFULL_W'(c_jlo_reg) + (JFULL_W'(c_jhi_reg) << 32);
        jmag_c  = JMAG_W'(jfull_c >> F);
        jlim_c  = c_ctrl_reg.res_neg ? (P_W'(1) << (P_W - 1)) : ((P_W'(1) << (P_W - 1)) - P_W'(1));
        jsat_c  = jmag_c > JMAG_W'(jlim_c);
        jm_c    = jsat_c ? jlim_c : jmag_c[P_W-1:0];
        d_ctrl_c      = c_ctrl_reg;
        d_ctrl_c.jsat = jsat_c && !c_ctrl_reg.req;
        d_ctrl_c.jump = c_ctrl_reg.req ? '0 : (c_ctrl_reg.res_neg ? (~jm_c + P_W'(1)) : jm_c);
    end

    logic              d_valid_reg;
    dfl_pkg::ctrl_t    d_ctrl_reg;
    logic [RAD_W-1:0]  d_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_ctrl_reg <= d_ctrl_c;
            d_rad_reg  <= c_rad_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage; index 0 is the stage D output
    // ------------------------------------------------------------------
    logic              sq_valid [0:ROOT_W];
    dfl_pkg::ctrl_t    sq_ctrl  [0:ROOT_W];
    logic [RADP_W-1:0] sq_rad   [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root  [0:ROOT_W];

    assign sq_valid[0] = d_valid_reg;
    assign sq_ctrl[0]  = d_ctrl_reg;
    assign sq_rad[0]   = RADP_W'(d_rad_reg);
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int PAIR = ROOT_W - 1 - k;
        logic [REM_W-1:0] rs_c, trial_c;
        logic             fit_c;

        always_comb
        begin
            rs_c    = {sq_rem[k][REM_W-3:0], sq_rad[k][2*PAIR+1 -: 2]};
            trial_c = {sq_root[k], 2'b01};
            fit_c   = rs_c >= trial_c;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid[k+1] <= 1'b0;
            else if (adv)
                sq_valid[k+1] <= sq_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_ctrl[k+1] <= sq_ctrl[k];
                sq_rad[k+1]  <= sq_rad[k];
                sq_rem[k+1]  <= fit_c ? (rs_c - trial_c) : rs_c;
                sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], fit_c};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: denominator a + sqrt(rad)
    // ------------------------------------------------------------------
    logic             e_valid_reg;
    dfl_pkg::ctrl_t   e_ctrl_reg;
    logic [DEN_W-1:0] e_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (adv)
            e_valid_reg <= sq_valid[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_ctrl_reg <= sq_ctrl[ROOT_W];
            e_den_reg  <= DEN_W'(sq_ctrl[ROOT_W].a) + DEN_W'(sq_root[ROOT_W]);
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: (2|P| << F) / den, one quotient bit per stage
    // ------------------------------------------------------------------
    logic             dv_valid [0:NUM_W];
    dfl_pkg::ctrl_t   dv_ctrl  [0:NUM_W];
    logic [DEN_W-1:0] dv_den   [0:NUM_W];
    logic [DEN_W-1:0] dv_rem   [0:NUM_W];
    logic [NUM_W-1:0] dv_q     [0:NUM_W];

    assign dv_valid[0] = e_valid_reg;
    assign dv_ctrl[0]  = e_ctrl_reg;
    assign dv_den[0]   = e_den_reg;
    assign dv_rem[0]   = '0;
    assign dv_q[0]     = '0;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        logic              nbit_c;
        logic [DREM_W-1:0] rs_c, dd_c, diff_c;
        logic              fit_c;

        // dividend is |P| followed by F+1 zero bits
        if (k < P_W)
        begin : g_bit
            assign nbit_c = dv_ctrl[k].pmag[P_W-1-k];
        end
        else
        begin : g_zero
            assign nbit_c = 1'b0;
        end

        always_comb
        begin
            rs_c   = {dv_rem[k], nbit_c};
            dd_c   = DREM_W'(dv_den[k]);
            diff_c = rs_c - dd_c;
            fit_c  = rs_c >= dd_c;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid[k+1] <= 1'b0;
            else if (adv)
                dv_valid[k+1] <= dv_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctrl[k+1] <= dv_ctrl[k];
                dv_den[k+1]  <= dv_den[k];
                dv_rem[k+1]  <= fit_c ? diff_c[DEN_W-1:0] : rs_c[DEN_W-1:0];
                dv_q[k+1]    <= {dv_q[k][NUM_W-2:0], fit_c};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly: speed saturation, sign and status
    // ------------------------------------------------------------------
    dfl_pkg::ctrl_t   fc;
    logic [NUM_W-1:0] q_c;
    logic [V_W-1:0]   vlim_c, vm_c, vel_c;
    logic             vsat_c;
    dfl_pkg::res_t    res_c;
    logic             res_valid;

    always_comb
    begin
        fc     = dv_ctrl[NUM_W];
        q_c    = dv_q[NUM_W];
        vlim_c = fc.res_neg ? (V_W'(1) << (V_W - 1)) : ((V_W'(1) << (V_W - 1)) - V_W'(1));
        vsat_c = q_c > NUM_W'(vlim_c);
        vm_c   = vsat_c ? vlim_c : q_c[V_W-1:0];
        vel_c  = fc.res_neg ? (~vm_c + V_W'(1)) : vm_c;
        res_c  = '0;
        priority if (fc.coef_zero)
            res_c.status = dfl_pkg::ST_COEF_ZERO;
        else if (!fc.req)
        begin
            res_c.jump   = fc.jump;
            res_c.status = fc.jsat ? dfl_pkg::ST_SATURATED : dfl_pkg::ST_OK;
        end
        else if (fc.pzero)
            res_c.status = dfl_pkg::ST_OK;
        else
        begin
            res_c.vel    = vel_c;
            res_c.status = vsat_c ? dfl_pkg::ST_SATURATED : dfl_pkg::ST_OK;
        end
        res_valid = dv_valid[NUM_W] && adv;
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic           out_valid_reg;
    dfl_pkg::res_t  out_reg, skid_reg;
    logic           out_load_res, out_load_skid, skid_load;

    always_comb
    begin
        out_load_skid = out_valid_reg && out_ready && skid_valid_reg;
        out_load_res  = res_valid && (!out_valid_reg || out_ready);
        skid_load     = res_valid && out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load_skid || out_load_res)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (out_load_skid)
                skid_valid_reg <= 1'b0;
            else if (skid_load)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
            out_reg <= skid_reg;
        else if (out_load_res)
            out_reg <= res_c;
        if (skid_load)
            skid_reg <= res_c;
    end

    assign out_valid    = out_valid_reg;
    assign jump_out     = $signed(out_reg.jump);
    assign velocity_out = $signed(out_reg.vel);
    assign status       = out_reg.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DFL_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `DFL_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg && !out_ready))
    `DFL_ASSERT_IMPL(a_coef_zero_clears, out_valid_reg && (status == dfl_pkg::ST_COEF_ZERO),
        (jump_out == '0) && (velocity_out == '0))
    `DFL_ASSERT_IMPL(a_one_field_used, out_valid_reg,
        (jump_out == '0) || (velocity_out == '0))

endmodule

// ===== dv/darcy_forchheimer_law_unit_test.sv =====
// ----------------------------------------------------------------------------
// darcy_forchheimer_law_unit_test
// Self-checking bench: directed table then random requests, scoreboarded
// against an in-bench fixed-point model of the porous law.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module darcy_forchheimer_law_unit_test;

    localparam int LATENCY    = 120;     // pipe is ~113 deep
    localparam int WATCH_MAX  = 20000;   // idle cycles before giving up
    localparam int N_RANDOM   = 700;
    localparam int HOLD_LEN   = 400;     // long receiver hold-off

    typedef enum logic {REQ_VEL = 1'b0, REQ_JUMP = 1'b1} req_kind_t;

    typedef struct {
        logic              req;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       v;
        logic [47:0]       p;
    } law_req_t;

    typedef struct {
        logic [47:0] jump;
        logic [31:0] vel;
        logic [1:0]  status;
    } law_res_t;

    // directed row: request plus an optional typed-in answer
    typedef struct {
        law_req_t    rq;
        logic        known;
        law_res_t    res;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [31:0]       lin_coeff;
    logic [31:0]       quad_coeff;
    logic signed [31:0] velocity_in;
    logic signed [47:0] jump_in;
    logic              out_valid;
    logic              out_ready;
    logic signed [47:0] jump_out;
    logic signed [31:0] velocity_out;
    logic [1:0]        status;

    law_res_t expected_results[$];
    int       n_errors = 0;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_recv;

    darcy_forchheimer_law_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .lin_coeff    (lin_coeff),
        .quad_coeff   (quad_coeff),
        .velocity_in  (velocity_in),
        .jump_in      (jump_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .jump_out     (jump_out),
        .velocity_out (velocity_out),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // floor(sqrt(x)) over a wide radicand, bit by bit
    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  cand;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = root | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= x)
                root = cand;
        end
        return root;
    endfunction

    // signed saturation of a magnitude into a width-bit field
    function automatic logic [63:0] sat_field(logic [127:0] mag, bit neg, int width,
                                              inout bit sat);
        logic [63:0] half;
        logic [63:0] limit;
        logic [63:0] m;
        logic [63:0] mask;
        half  = 64'd1 << (width - 1);
        mask  = (64'd1 << width) - 64'd1;
        limit = neg ? half : half - 64'd1;
        if (mag > {64'd0, limit})
        begin
            sat = 1'b1;
            m   = limit;
        end
        else
            m = mag[63:0];
        return neg ? ((~m + 64'd1) & mask) : (m & mask);
    endfunction

    // porous law: velocity -> jump, or jump -> velocity
    function automatic law_res_t porous_law(law_req_t rq);
        law_res_t     r;
        bit           sat;
        bit           neg;
        logic [63:0]  mag;
        logic [127:0] quad;
        logic [127:0] jmag;
        logic [127:0] rad;
        logic [63:0]  den;
        logic [127:0] spd;
        logic [63:0]  field;
        r   = '{jump: '0, vel: '0, status: dfl_pkg::ST_OK};
        sat = 1'b0;
        if (rq.a == 0 && rq.b == 0)
        begin
            r.status = dfl_pkg::ST_COEF_ZERO;
            return r;
        end
        if (rq.req == REQ_VEL)
        begin
            neg  = rq.v[31];
            mag  = neg ? {32'd0, -rq.v} : {32'd0, rq.v};
            if (neg && mag == 0)
                mag = 64'd1 << 31;
            quad = ({96'd0, rq.b} * {64'd0, mag}) >> dfl_pkg::FRAC_BITS;
            jmag = ({64'd0, mag} * ({96'd0, rq.a} + quad)) >> dfl_pkg::FRAC_BITS;
            if (jmag != 0)
            begin
                field  = sat_field(jmag, !neg, 48, sat);
                r.jump = field[47:0];
            end
        end
        else
        begin
            neg = rq.p[47];
            mag = neg ? {16'd0, -rq.p} : {16'd0, rq.p};
            if (neg && mag == 0)
                mag = 64'd1 << 47;
            if (mag == 0)
                return r;
            rad = {96'd0, rq.a} * {96'd0, rq.a} + (({96'd0, rq.b} * {64'd0, mag}) << 2);
            den = {32'd0, rq.a} + isqrt(rad);
            spd = ({64'd0, mag} << (1 + dfl_pkg::FRAC_BITS)) / {64'd0, den};
            if (spd != 0)
            begin
                field = sat_field(spd, !neg, 32, sat);
                r.vel = field[31:0];
            end
        end
        r.status = sat ? dfl_pkg::ST_SATURATED : dfl_pkg::ST_OK;
        return r;
    endfunction

    // one transfer on the input side, with random idle before it
    task automatic send_request(law_req_t rq, law_res_t exp_res);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rq.req;
        lin_coeff   <= rq.a;
        quad_coeff  <= rq.b;
        velocity_in <= rq.v;
        jump_in     <= rq.p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.insert(expected_results.size(), exp_res);
    endtask

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return $urandom_range(255);
            2:       return $urandom_range(32'h0003_0000);   // up to 3.0
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic law_req_t rand_request();
        law_req_t rq;
        rq.req = 1'($urandom_range(1));
        rq.a   = rand_coeff();
        rq.b   = rand_coeff();
        case ($urandom_range(3))
            0:       rq.v = $signed($urandom_range(32'h0004_0000)) * ($urandom_range(1) ? 1 : -1);
            default: rq.v = $urandom;
        endcase
        case ($urandom_range(3))
            0:       rq.p = {16'd0, $urandom} * ($urandom_range(1) ? 48'd1 : -48'd1);
            1:       rq.p = $urandom_range(255) * ($urandom_range(1) ? 48'd1 : -48'd1);
            default: rq.p = 48'({$urandom, $urandom});
        endcase
        return rq;
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCH_MAX)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer");
                    n_errors++;
                end
                else
                begin
                    law_res_t e;
                    e = expected_results.pop_front();
                    if (jump_out !== e.jump)
                    begin
                        $error("jump_out exp %h got %h", e.jump, jump_out);
                        n_errors++;
                    end
                    if (velocity_out !== e.vel)
                    begin
                        $error("velocity_out exp %h got %h", e.vel, velocity_out);
                        n_errors++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, status);
                        n_errors++;
                    end
                end
            end
        end
    end

    // long receiver hold-off, counted here while the sender keeps going
    task automatic hold_off_receiver();
        hold_recv = 1'b1;
        repeat (HOLD_LEN)
            @(posedge clk);
        hold_recv = 1'b0;
    endtask

    initial
    begin
        row_t rows[$];
        law_req_t rnd_rq;
        int wait_cycles;
        hold_recv     = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 63;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = 1'b0;
        lin_coeff     = '0;
        quad_coeff    = '0;
        velocity_in   = '0;
        jump_in       = '0;

        // directed table; answers typed in where they are obvious
        rows.insert(rows.size(), '{'{REQ_VEL, 0, 0, 32'h0001_0000, 0}, 1,
                                   '{0, 0, dfl_pkg::ST_COEF_ZERO}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 0, 0, 0, 48'h1_0000}, 1,
                                   '{0, 0, dfl_pkg::ST_COEF_ZERO}});
        rows.insert(rows.size(), '{'{REQ_VEL, 32'h1_0000, 0, 0, 0}, 1,
                                   '{0, 0, dfl_pkg::ST_OK}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 32'h1_0000, 0, 0, 0}, 1,
                                   '{0, 0, dfl_pkg::ST_OK}});
        // a = 1, v = 1 -> jump -1
        rows.insert(rows.size(), '{'{REQ_VEL, 32'h1_0000, 0, 32'h1_0000, 0}, 1,
                                   '{48'hFFFF_FFFF_0000, 0, dfl_pkg::ST_OK}});
        // extremes saturate
        rows.insert(rows.size(), '{'{REQ_VEL, '1, '1, 32'h8000_0000, 0}, 1,
                                   '{48'h7FFF_FFFF_FFFF, 0, dfl_pkg::ST_SATURATED}});
        rows.insert(rows.size(), '{'{REQ_VEL, '1, '1, 32'h7FFF_FFFF, 0}, 1,
                                   '{48'h8000_0000_0000, 0, dfl_pkg::ST_SATURATED}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 1, 0, 0, 48'h8000_0000_0000}, 1,
                                   '{0, 32'h7FFF_FFFF, dfl_pkg::ST_SATURATED}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 1, 0, 0, 48'h7FFF_FFFF_FFFF}, 1,
                                   '{0, 32'h8000_0000, dfl_pkg::ST_SATURATED}});
        // answers from the model; the first row's speed truncates to zero
        rows.insert(rows.size(), '{'{REQ_JUMP, '1, 0, 0, 48'd1}, 0, '{0, 0, 0}});
        rows.insert(rows.size(), '{'{REQ_JUMP, '1, '1, 0, 48'h7FFF_FFFF_FFFF}, 0,
                                   '{0, 0, 0}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 0, 32'h1_0000, 0, 48'hFFFF_FFFF_0000}, 0,
                                   '{0, 0, 0}});
        rows.insert(rows.size(), '{'{REQ_VEL, 0, 32'h1_0000, 32'hFFFF_0000, 0}, 0,
                                   '{0, 0, 0}});
        rows.insert(rows.size(), '{'{REQ_VEL, 32'h8000_0000, 32'h1, 32'h0000_0001, 0}, 0,
                                   '{0, 0, 0}});
        rows.insert(rows.size(), '{'{REQ_JUMP, 32'h2_0000, 32'h3_0000, 0, 48'h5_8000}, 0,
                                   '{0, 0, 0}});

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].known)
                send_request(rows[i].rq, rows[i].res);
            else
                send_request(rows[i].rq, porous_law(rows[i].rq));
        end

        // three idling phases, long hold-off inside the last
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 38 : 0;
            if (ph == 2)
                fork
                    hold_off_receiver();
                join_none
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                rnd_rq = rand_request();
                send_request(rnd_rq, porous_law(rnd_rq));
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 50 * WATCH_MAX)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY)
            @(posedge clk);

        if (n_errors == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
